[hw/rtl/cfsc_pkg.sv]
package cfsc_pkg;

    localparam int WORD_W          = 16;
    localparam int WORDS_PER_FRAME = 4;
    localparam int LANE_W          = 2;
    localparam int SLOT_W          = 5;
    localparam int INDEX_W         = 7;
    localparam int ROW_W           = INDEX_W - LANE_W;
    localparam int ELAPSED_W       = 17;
    localparam int ID_COUNT        = 18;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [10:0] ID_TABLE [ID_COUNT] = '{
        11'h300, 11'h301, 11'h303, 11'h304, 11'h306, 11'h309, 11'h30A, 11'h30B, 11'h30E,
        11'h310, 11'h311, 11'h312, 11'h313, 11'h314, 11'h315, 11'h320, 11'h322, 11'h32F
    };

    typedef struct packed {
        logic [1:0]  operation;
        logic [10:0] std_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [6:0]  reg_index;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        data_ready;
        logic        timed_out;
        logic        frame_accepted;
        logic        set_complete;
        logic [4:0]  frame_slot;
    } result_t;

    typedef struct packed {
        logic                                    en;
        logic [SLOT_W-1:0]                       slot;
        logic [WORDS_PER_FRAME-1:0]              word_en;
        logic [WORDS_PER_FRAME-1:0][WORD_W-1:0]  words;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] lane;
    } store_rd_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } id_match_t;

    // IDs are distinct, so at most one compare hits
    function automatic id_match_t id_lookup(logic [10:0] id);
        id_match_t m;
        m.hit  = 1'b0;
        m.slot = '0;
        for (int k = 0; k < ID_COUNT; k++)
        begin
            if (ID_TABLE[k] == id)
            begin
                m.hit  = 1'b1;
                m.slot = SLOT_W'(k);
            end
        end
        return m;
    endfunction

endpackage

[hw/rtl/can_frame_set_collector_core.sv]
// Collects a set of CAN frames into a store of 16-bit registers.
// Command channel: an item (frame, tick or register read) is taken at a
// clock edge with start high and busy low; busy never rises, so one item
// can be issued every cycle.
// Result channel: done pulses for one cycle with result holding the
// outcome of one item, in issue order. The receiver cannot stall, so it
// must take every result in the cycle it is shown.
// Pipeline: the result passes the input register, then the result register
// together with the store's registered read port. Throughput: one item
// per cycle.
// Config channel: cfg_data is the timeout in ticks, written when
// cfg_valid and cfg_ready are high; cfg_ready is always high. Write it
// only while no item is in flight.
// Reset: the store reads as zero, the mask, ready flag, received flag and
// tick count clear, and the timeout returns to 1000 ticks. No clearing
// pass is needed; the block takes items straight after reset.
module can_frame_set_collector_core #(
    parameter int FRAME_SLOTS = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cfsc_pkg::item_t     item,
    output logic                done,
    output cfsc_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import cfsc_pkg::*;

    localparam logic [FRAME_SLOTS-1:0] FULL_MASK   = {FRAME_SLOTS{1'b1}};
    localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam int                     STORE_DEPTH = FRAME_SLOTS * WORDS_PER_FRAME;

    item_t                  item_reg;
    logic                   item_vld_reg;
    logic [15:0]            timeout_reg;
    logic [FRAME_SLOTS-1:0] mask_reg, mask_next;
    logic                   ready_reg, ready_next;
    logic                   ever_reg, ever_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    result_t                res_reg, res_next;
    logic                   done_reg;

    id_match_t              id_m;
    logic                   accept;
    logic                   complete;
    logic [FRAME_SLOTS-1:0] mask_or;
    store_wr_t              wr;
    store_rd_t              rd;
    logic [WORD_W-1:0]      read_data;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= item;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
            mask_reg     <= '0;
            ready_reg    <= 1'b0;
            ever_reg     <= 1'b0;
            elapsed_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            item_vld_reg <= start;
            if (cfg_valid)
            begin
                timeout_reg <= cfg_data;
            end
            mask_reg    <= mask_next;
            ready_reg   <= ready_next;
            ever_reg    <= ever_next;
            elapsed_reg <= elapsed_next;
            done_reg    <= item_vld_reg;
        end
    end

    always_comb
    begin
        id_m   = id_lookup(item_reg.std_id);
        accept = item_vld_reg && (item_reg.operation == OP_FRAME)
                 && !item_reg.is_extended && !item_reg.is_remote && id_m.hit
                 && ({1'b0, id_m.slot} < (SLOT_W + 1)'(FRAME_SLOTS));

        mask_or  = mask_reg | (FRAME_SLOTS'(1) << id_m.slot);
        complete = accept && (mask_or == FULL_MASK);

        mask_next = mask_reg;
        if (accept)
        begin
            mask_next = complete ? '0 : mask_or;
        end
        ready_next = ready_reg | complete;
        ever_next  = ever_reg | accept;

        elapsed_next = elapsed_reg;
        if (accept)
        begin
            elapsed_next = '0;
        end
        else if (item_vld_reg && (item_reg.operation == OP_TICK)
                 && (elapsed_reg != ELAPSED_MAX))
        begin
            elapsed_next = elapsed_reg + 1'b1;
        end

        res_next.read_data      = '0;
        res_next.data_ready     = ready_next;
        res_next.timed_out      = !ever_next
                                  || (elapsed_next > {{(ELAPSED_W - 16){1'b0}}, timeout_reg});
        res_next.frame_accepted = accept;
        res_next.set_complete   = complete;
        res_next.frame_slot     = accept ? id_m.slot : '0;

        // word i needs payload bytes 2i and 2i+1
        wr.en   = accept;
        wr.slot = id_m.slot;
        for (int i = 0; i < WORDS_PER_FRAME; i++)
        begin
            wr.word_en[i] = (item_reg.dlc > 4'(2 * i + 1));
            wr.words[i]   = item_reg.payload[63 - WORD_W * i -: WORD_W];
        end

        rd.en   = item_vld_reg && (item_reg.operation == OP_READ)
                  && ({1'b0, item_reg.reg_index} < (INDEX_W + 1)'(STORE_DEPTH));
        rd.row  = item_reg.reg_index[INDEX_W-1:LANE_W];
        rd.lane = item_reg.reg_index[LANE_W-1:0];
    end

    cfsc_store #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd        (rd),
        .read_data (read_data)
    );

    always_comb
    begin
        result           = res_reg;
        result.read_data = read_data;
    end

    assign done = done_reg;

endmodule

[hw/rtl/cfsc_store.sv]
module cfsc_store #(
    parameter int FRAME_SLOTS = 18
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfsc_pkg::store_wr_t                wr,
    input  cfsc_pkg::store_rd_t                rd,
    output logic [cfsc_pkg::WORD_W-1:0]        read_data
);
    import cfsc_pkg::*;

    localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

    logic [WORD_W-1:0]      lane_q_reg [WORDS_PER_FRAME];
    logic [FRAME_SLOTS-1:0] vld_reg    [WORDS_PER_FRAME];
    logic                   hit_reg;
    logic [LANE_W-1:0]      lane_reg;

    // one memory per word lane, rows indexed by frame slot
    for (genvar g = 0; g < WORDS_PER_FRAME; g++)
    begin : g_lane
        logic [WORD_W-1:0] mem [FRAME_SLOTS];

        always_ff @(posedge clk)
        begin
            if (wr.en && wr.word_en[g])
            begin
                mem[wr.slot[IDX_W-1:0]] <= wr.words[g];
            end
            if (rd.en)
            begin
                lane_q_reg[g] <= mem[rd.row[IDX_W-1:0]];
            end
        end

        // entries never written read as zero
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= '0;
            end
            else if (wr.en && wr.word_en[g])
            begin
                vld_reg[g][wr.slot[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            lane_reg <= '0;
        end
        else
        begin
            hit_reg  <= rd.en && vld_reg[rd.lane][rd.row[IDX_W-1:0]];
            lane_reg <= rd.lane;
        end
    end

    assign read_data = hit_reg ? lane_q_reg[lane_reg] : '0;

endmodule
